### src/terminal_escape_line_editor_top_macros.svh
`ifndef TERMINAL_ESCAPE_LINE_EDITOR_TOP_MACROS_SVH
`define TERMINAL_ESCAPE_LINE_EDITOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define TELE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define TELE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/tele_pkg.sv
`timescale 1ns / 1ps

package tele_pkg;

  localparam int LINE_DEPTH_DEF  = 60;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] TIMEOUT_RESET = 8'd5;

  // Input item kinds.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_ARM  = 2'd2;

  // Result kinds.
  localparam logic [2:0] OUT_ECHO     = 3'd0;
  localparam logic [2:0] OUT_TOKEN    = 3'd1;
  localparam logic [2:0] OUT_CHAR     = 3'd2;
  localparam logic [2:0] OUT_LINE_END = 3'd3;
  localparam logic [2:0] OUT_HALT     = 3'd4;
  localparam logic [2:0] OUT_RESET    = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_RESET    = 8'h19;
  localparam logic [7:0] CH_HALT     = 8'h1A;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SP       = 8'h20;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [31:0] BYTE_MAX   = 32'h0000_00FF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rx_byte;
    logic [15:0] repeat_delay;
  } item_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [31:0] out_value;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    CMD_HALT,
    CMD_RESET,
    CMD_TOKEN,
    CMD_CHAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    return (d < 4'd10) ? (8'h30 + {4'h0, d}) : (8'h37 + {4'h0, d});
  endfunction

endpackage

### src/tele_queue.sv
`timescale 1ns / 1ps
`include "terminal_escape_line_editor_top_macros.svh"

module tele_queue #(
  parameter int DEPTH = tele_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tele_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output tele_pkg::cmd_t      head,
  output tele_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tele_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head         = mem[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TELE_ASSERT(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "queue count beyond depth")
  `TELE_ASSERT(a_no_overflow, push, !status.full || pop, "push into a full queue")
  `TELE_ASSERT_NEXT(a_pop_drains, pop && !push, count == $past(count) - 1'b1, "pop lost")

endmodule

### src/tele_front.sv
`timescale 1ns / 1ps

module tele_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  tele_pkg::item_t item,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_data,
  output logic            push,
  output tele_pkg::cmd_t  push_cmd
);

  typedef enum logic [1:0] {
    T_OFF,
    T_GATHER,
    T_REPEAT
  } timer_mode_t;

  timer_mode_t mode;
  timer_mode_t mode_next;
  logic [15:0] ticks_left;
  logic [15:0] ticks_left_next;
  logic [31:0] seq_code;
  logic [31:0] seq_code_next;
  logic [7:0]  timeout;
  logic [31:0] gathered;
  logic        term;
  logic        deliver;
  logic [31:0] dval;

  assign gathered = {seq_code[23:0], item.rx_byte};
  assign term     = (item.rx_byte == tele_pkg::CH_TILDE) ||
                    ((item.rx_byte >= tele_pkg::CH_A) && (item.rx_byte <= tele_pkg::CH_D));

  always_comb begin
    mode_next       = mode;
    ticks_left_next = ticks_left;
    seq_code_next   = seq_code;
    deliver         = 1'b0;
    dval            = '0;
    if (accept) begin
      unique case (item.kind)
        tele_pkg::KIND_BYTE: begin
          if (mode == T_GATHER) begin
            seq_code_next = gathered;
            if (term) begin
              mode_next       = T_OFF;
              ticks_left_next = '0;
              deliver         = 1'b1;
              dval            = gathered;
            end
          end else if (item.rx_byte == tele_pkg::CH_ESC) begin
            mode_next       = T_GATHER;
            ticks_left_next = {8'h00, timeout};
            seq_code_next   = {24'h0, tele_pkg::CH_ESC};
          end else begin
            mode_next       = T_OFF;
            ticks_left_next = '0;
            deliver         = 1'b1;
            dval            = {24'h0, item.rx_byte};
          end
        end
        tele_pkg::KIND_TICK: begin
          if (mode != T_OFF) begin
            if (ticks_left == '0) begin
              mode_next = T_OFF;
              deliver   = 1'b1;
              dval      = seq_code;
            end else begin
              ticks_left_next = ticks_left - 1'b1;
            end
          end
        end
        tele_pkg::KIND_ARM: begin
          mode_next       = T_REPEAT;
          ticks_left_next = item.repeat_delay;
        end
        default: begin
        end
      endcase
    end
  end

  // A line feed leaves no trace anywhere, so it is dropped here.
  always_comb begin
    push           = deliver && (dval != {24'h0, tele_pkg::CH_LF});
    push_cmd.value = dval;
    priority if (dval == {24'h0, tele_pkg::CH_HALT}) begin
      push_cmd.op = tele_pkg::CMD_HALT;
    end else if (dval == {24'h0, tele_pkg::CH_RESET}) begin
      push_cmd.op = tele_pkg::CMD_RESET;
    end else if (dval > tele_pkg::BYTE_MAX) begin
      push_cmd.op = tele_pkg::CMD_TOKEN;
    end else begin
      push_cmd.op = tele_pkg::CMD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= T_OFF;
      ticks_left <= '0;
      seq_code   <= '0;
      timeout    <= tele_pkg::TIMEOUT_RESET;
    end else begin
      mode       <= mode_next;
      ticks_left <= ticks_left_next;
      seq_code   <= seq_code_next;
      if (cfg_we) begin
        timeout <= cfg_data;
      end
    end
  end

endmodule

### src/tele_back.sv
`timescale 1ns / 1ps
`include "terminal_escape_line_editor_top_macros.svh"

module tele_back #(
  parameter int LINE_DEPTH = tele_pkg::LINE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tele_pkg::cmd_t      head,
  input  tele_pkg::q_status_t q_status,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output tele_pkg::result_t   result
);

  localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int LEN_W = $clog2(LINE_DEPTH + 1);

  typedef enum logic [2:0] {
    B_IDLE,
    B_SINGLE,
    B_BS,
    B_HEX,
    B_CR_ADDR,
    B_CR_CHAR,
    B_CR_END,
    B_CR_TAIL
  } back_state_t;

  back_state_t       state;
  logic [1:0]        cnt;
  logic [2:0]        s_kind;
  logic [31:0]       s_value;
  logic [LEN_W-1:0]  len;
  logic [IDX_W-1:0]  rd_idx;
  logic [7:0]        rd_data;
  logic [7:0]        line_mem [LINE_DEPTH];
  logic [7:0]        c;
  logic              printable;
  logic              mem_we;
  logic              emit_req;
  logic              can_emit;
  logic              go;
  tele_pkg::result_t emit_item;

  assign c         = head.value[7:0];
  assign printable = (c >= tele_pkg::CH_PRINT_LO) && (c <= tele_pkg::CH_PRINT_HI);
  assign pop       = (state == B_IDLE) && !q_status.empty;
  assign mem_we    = pop && (head.op == tele_pkg::CMD_CHAR) && printable &&
                     (len < LEN_W'(LINE_DEPTH));
  assign can_emit  = !result_valid || !result_stall;
  assign go        = emit_req && can_emit;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[len[IDX_W-1:0]] <= c;
    end
    rd_data <= line_mem[rd_idx];
  end

  always_comb begin
    emit_req  = 1'b1;
    emit_item = '{out_kind: tele_pkg::OUT_ECHO, out_value: '0, last: 1'b0};
    unique case (state)
      B_SINGLE: begin
        emit_item = '{out_kind: s_kind, out_value: s_value, last: 1'b1};
      end
      B_BS: begin
        emit_item.out_value = {24'h0, (cnt == 2'd1) ? tele_pkg::CH_SP : tele_pkg::CH_BS};
        emit_item.last      = (cnt == 2'd2);
      end
      B_HEX: begin
        unique case (cnt)
          2'd0:    emit_item.out_value = {24'h0, tele_pkg::CH_LT};
          2'd1:    emit_item.out_value = {24'h0, tele_pkg::hex_digit(s_value[7:4])};
          2'd2:    emit_item.out_value = {24'h0, tele_pkg::hex_digit(s_value[3:0])};
          default: emit_item.out_value = {24'h0, tele_pkg::CH_GT};
        endcase
        emit_item.last = (cnt == 2'd3);
      end
      B_CR_CHAR: begin
        emit_item.out_kind  = tele_pkg::OUT_CHAR;
        emit_item.out_value = {24'h0, rd_data};
      end
      B_CR_END: begin
        emit_item.out_kind  = tele_pkg::OUT_LINE_END;
        emit_item.out_value = 32'(len);
      end
      B_CR_TAIL: begin
        unique case (cnt)
          2'd0:    emit_item.out_value = {24'h0, tele_pkg::CH_CR};
          2'd1:    emit_item.out_value = {24'h0, tele_pkg::CH_LF};
          default: emit_item.out_value = {24'h0, tele_pkg::CH_GT};
        endcase
        emit_item.last = (cnt == 2'd2);
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
      len          <= '0;
      cnt          <= '0;
      rd_idx       <= '0;
    end else begin
      if (go) begin
        result_valid <= 1'b1;
        result       <= emit_item;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        B_IDLE: begin
          if (pop) begin
            cnt    <= '0;
            rd_idx <= '0;
            unique case (head.op)
              tele_pkg::CMD_HALT: begin
                s_kind  <= tele_pkg::OUT_HALT;
                s_value <= '0;
                state   <= B_SINGLE;
              end
              tele_pkg::CMD_RESET: begin
                s_kind  <= tele_pkg::OUT_RESET;
                s_value <= '0;
                state   <= B_SINGLE;
              end
              tele_pkg::CMD_TOKEN: begin
                s_kind  <= tele_pkg::OUT_TOKEN;
                s_value <= head.value;
                state   <= B_SINGLE;
              end
              default: begin
                priority if ((c == tele_pkg::CH_BS) || (c == tele_pkg::CH_DEL)) begin
                  if (len != '0) begin
                    len   <= len - 1'b1;
                    state <= B_BS;
                  end
                end else if (c == tele_pkg::CH_CR) begin
                  state <= (len == '0) ? B_CR_END : B_CR_ADDR;
                end else if (printable) begin
                  if (len < LEN_W'(LINE_DEPTH)) begin
                    len     <= len + 1'b1;
                    s_kind  <= tele_pkg::OUT_ECHO;
                    s_value <= {24'h0, c};
                    state   <= B_SINGLE;
                  end
                end else begin
                  s_value <= {24'h0, c};
                  state   <= B_HEX;
                end
              end
            endcase
          end
        end
        B_SINGLE: begin
          if (go) begin
            state <= B_IDLE;
          end
        end
        B_BS, B_CR_TAIL: begin
          if (go) begin
            cnt <= cnt + 1'b1;
            if (cnt == 2'd2) begin
              state <= B_IDLE;
            end
          end
        end
        B_HEX: begin
          if (go) begin
            cnt <= cnt + 1'b1;
            if (cnt == 2'd3) begin
              state <= B_IDLE;
            end
          end
        end
        B_CR_ADDR: begin
          state <= B_CR_CHAR;
        end
        B_CR_CHAR: begin
          if (go) begin
            if (LEN_W'(rd_idx) + LEN_W'(1) == len) begin
              state <= B_CR_END;
            end else begin
              rd_idx <= rd_idx + 1'b1;
              state  <= B_CR_ADDR;
            end
          end
        end
        default: begin
          if (go) begin
            len   <= '0;
            cnt   <= '0;
            state <= B_CR_TAIL;
          end
        end
      endcase
    end
  end

  `TELE_ASSERT(a_len_bound, 1'b1, len <= LEN_W'(LINE_DEPTH), "line length beyond depth")
  `TELE_ASSERT(a_read_in_line, state == B_CR_CHAR, LEN_W'(rd_idx) < len, "read past line end")
  `TELE_ASSERT_NEXT(a_last_to_idle, go && emit_item.last, state == B_IDLE, "no idle after last")

endmodule

### src/terminal_escape_line_editor_top.sv
`timescale 1ns / 1ps
// Channel     Direction  Handshake                  Payload
// item        in         item_valid / item_stall    tele_pkg::item_t
// result      out        result_valid / result_stall tele_pkg::result_t
// cfg         in         cfg_we                     cfg_data (escape timeout, ticks)
//
// The front handles an item in its acceptance cycle; a delivered value is written into the
// command queue, popped by the back and answered through the registered result channel.
// A carriage return passes each stored character through B_CR_ADDR and B_CR_CHAR (one
// registered line memory read each) and then gives four more results.
// Reset (rst, synchronous) empties the line, stops the timer and sets the timeout to 5.
// item_stall rises only when the four-entry command queue is full.

module terminal_escape_line_editor_top #(
  parameter int LINE_DEPTH  = tele_pkg::LINE_DEPTH_DEF,
  parameter int QUEUE_DEPTH = tele_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  tele_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output tele_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data
);

  // The front owns the escape gathering and the millisecond timer. Every transaction on the
  // item channel is handled in its acceptance cycle and may yield one command for the back.
  logic                accept;
  logic                push;
  logic                pop;
  tele_pkg::cmd_t      push_cmd;
  tele_pkg::cmd_t      head;
  tele_pkg::q_status_t q_status;

  // The stall only depends on queue occupancy, so a new transaction is taken even while
  // a finished result waits in the output register.
  assign item_stall = q_status.full;
  assign accept     = item_valid && !item_stall;

  tele_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // The queue decouples the two halves: a long line drain in the back does not block ticks
  // and bytes at the front until the queue fills.
  tele_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // The back runs the line editor and drives the registered result channel. It marks the
  // final result of each command with last.
  tele_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### dv/terminal_escape_line_editor_top_test.sv
`timescale 1ns / 1ps

module terminal_escape_line_editor_top_test;
  import tele_pkg::*;

  localparam int LINE_DEPTH = LINE_DEPTH_DEF;
  localparam int CLK_HALF = 4;
  // Quiet time after the last result before the timeout register may change.
  // Items such as ESC or a tick leave no result, so this covers the front end
  // and the four-entry command queue with margin.
  localparam int SETTLE_CYCLES = 40;
  // Cycles with no transaction on either channel before the run is abandoned.
  // A full line drains one character at a time, so real gaps stay short.
  localparam int STALL_LIMIT = 4000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [7:0] ASCII_DIGIT_0 = 8'h30;
  localparam logic [7:0] ASCII_LBRACKET = 8'h5B;
  localparam logic [7:0] ASCII_X = 8'h78;

  typedef enum logic [1:0] {
    TIMER_OFF,
    TIMER_GATHER,
    TIMER_REPEAT
  } timer_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = TIMEOUT_RESET;

  terminal_escape_line_editor_top dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // Terminal input waiting to be offered to the block, and the editor output
  // that the accepted input is known to produce, oldest first.
  item_t terminal_inputs_queued[$];
  result_t terminal_outputs_due[$];

  // Our own copy of the editor: line buffer, escape gathering and the timer.
  logic [7:0] line_chars[LINE_DEPTH];
  int unsigned line_len = 0;
  logic [31:0] seq_code = '0;
  timer_state_t timer_state = TIMER_OFF;
  logic [16:0] ticks_remaining = '0;
  logic [7:0] esc_timeout = TIMEOUT_RESET;

  // When set, neither side of the block inserts idle or stall cycles.
  bit quiet_phase = 1'b0;
  int mismatch_count = 0;
  int inputs_accepted = 0;
  int outputs_checked = 0;
  int inputs_queued_total = 0;
  int quiet_cycles = 0;

  function automatic bit side_idles();
    return !quiet_phase && ($urandom_range(99) < 24);
  endfunction

  function automatic logic [7:0] nibble_to_ascii(input logic [3:0] d);
    return (d < 4'd10) ? ASCII_DIGIT_0 + {4'h0, d} : CH_A + {4'h0, d - 4'd10};
  endfunction

  task automatic emit_output(input logic [2:0] k, input logic [31:0] v);
    result_t r;
    r.out_kind = k;
    r.out_value = v;
    r.last = 1'b0;
    terminal_outputs_due.push_back(r);
  endtask

  task automatic edit_line(input logic [7:0] c);
    if (c == CH_BS || c == CH_DEL) begin
      // Erase echoes back-space, space, back-space; nothing happens on an empty line.
      if (line_len > 0) begin
        line_len--;
        emit_output(OUT_ECHO, {24'd0, CH_BS});
        emit_output(OUT_ECHO, {24'd0, CH_SP});
        emit_output(OUT_ECHO, {24'd0, CH_BS});
      end
    end else if (c == CH_LF) begin
      // Line feed is swallowed.
    end else if (c == CH_CR) begin
      for (int i = 0; i < line_len; i++) emit_output(OUT_CHAR, {24'd0, line_chars[i]});
      emit_output(OUT_LINE_END, line_len);
      emit_output(OUT_ECHO, {24'd0, CH_CR});
      emit_output(OUT_ECHO, {24'd0, CH_LF});
      emit_output(OUT_ECHO, {24'd0, CH_GT});
      line_len = 0;
    end else if (c >= CH_PRINT_LO && c <= CH_PRINT_HI) begin
      // A full line drops printable characters without any echo.
      if (line_len < LINE_DEPTH) begin
        line_chars[line_len] = c;
        line_len++;
        emit_output(OUT_ECHO, {24'd0, c});
      end
    end else begin
      emit_output(OUT_ECHO, {24'd0, CH_LT});
      emit_output(OUT_ECHO, {24'd0, nibble_to_ascii(c[7:4])});
      emit_output(OUT_ECHO, {24'd0, nibble_to_ascii(c[3:0])});
      emit_output(OUT_ECHO, {24'd0, CH_GT});
    end
  endtask

  task automatic dispatch_code(input logic [31:0] v);
    if (v == {24'd0, CH_HALT}) emit_output(OUT_HALT, '0);
    else if (v == {24'd0, CH_RESET}) emit_output(OUT_RESET, '0);
    else if (v > BYTE_MAX) emit_output(OUT_TOKEN, v);
    else edit_line(v[7:0]);
  endtask

  // Works out what one accepted terminal input produces and updates our state.
  task automatic decode_terminal_item(input item_t it);
    int first;
    result_t tail;
    first = terminal_outputs_due.size();
    case (it.kind)
      KIND_BYTE: begin
        if (timer_state == TIMER_GATHER) begin
          seq_code = {seq_code[23:0], it.rx_byte};
          if (it.rx_byte == CH_TILDE || (it.rx_byte >= CH_A && it.rx_byte <= CH_D)) begin
            timer_state = TIMER_OFF;
            ticks_remaining = '0;
            dispatch_code(seq_code);
          end
        end else if (it.rx_byte == CH_ESC) begin
          timer_state = TIMER_GATHER;
          ticks_remaining = {9'd0, esc_timeout};
          seq_code = {24'd0, CH_ESC};
        end else begin
          // A plain byte also cancels a pending repeat.
          timer_state = TIMER_OFF;
          ticks_remaining = '0;
          dispatch_code({24'd0, it.rx_byte});
        end
      end
      KIND_TICK: begin
        if (timer_state != TIMER_OFF) begin
          if (ticks_remaining == '0) begin
            timer_state = TIMER_OFF;
            dispatch_code(seq_code);
          end else begin
            ticks_remaining = ticks_remaining - 17'd1;
          end
        end
      end
      KIND_ARM: begin
        timer_state = TIMER_REPEAT;
        ticks_remaining = {1'b0, it.repeat_delay};
      end
      default: begin
      end
    endcase
    if (terminal_outputs_due.size() > first) begin
      tail = terminal_outputs_due[terminal_outputs_due.size() - 1];
      tail.last = 1'b1;
      terminal_outputs_due[terminal_outputs_due.size() - 1] = tail;
    end
  endtask

  // Input driver. A stalled transaction is held unchanged; otherwise the next
  // queued input is offered unless this cycle is picked as an idle one. The
  // prediction is made at the edge where the block takes the transaction.
  always @(posedge clk) begin : item_driver
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        decode_terminal_item(item);
        inputs_accepted++;
      end
      if (item_valid && item_stall) begin
        // Hold the payload until the block takes it.
      end else if (terminal_inputs_queued.size() != 0 && !side_idles()) begin
        item <= terminal_inputs_queued.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Output monitor. Every accepted result is checked against the oldest
  // predicted one; the stall for the next cycle is chosen at random.
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      outputs_checked++;
      if (terminal_outputs_due.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: MISMATCH unexpected result kind %0d value %h last %b",
                 $time, result.out_kind, result.out_value, result.last);
      end else begin
        want = terminal_outputs_due.pop_front();
        if (result.out_kind !== want.out_kind) begin
          mismatch_count++;
          $display("%0t ns: MISMATCH out_kind expected %0d actual %0d",
                   $time, want.out_kind, result.out_kind);
        end
        if (result.out_value !== want.out_value) begin
          mismatch_count++;
          $display("%0t ns: MISMATCH out_value expected %h actual %h",
                   $time, want.out_value, result.out_value);
        end
        if (result.last !== want.last) begin
          mismatch_count++;
          $display("%0t ns: MISMATCH last expected %b actual %b",
                   $time, want.last, result.last);
        end
      end
    end
    result_stall <= side_idles();
  end

  // Watchdog: the run is over if neither channel moves for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus helpers. Fields that the kind does not use carry random values so
  // that every bit of every field is exercised.
  task automatic queue_input(input logic [1:0] k, input logic [7:0] b, input logic [15:0] d);
    item_t it;
    it.kind = k;
    it.rx_byte = b;
    it.repeat_delay = d;
    terminal_inputs_queued.push_back(it);
    inputs_queued_total++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    queue_input(KIND_BYTE, b, 16'($urandom));
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_input(KIND_TICK, 8'($urandom), 16'($urandom));
  endtask

  task automatic queue_arm(input logic [15:0] d);
    queue_input(KIND_ARM, 8'($urandom), d);
  endtask

  function automatic logic [7:0] random_printable();
    return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
  endfunction

  // A byte that does not close an escape sequence.
  function automatic logic [7:0] random_inner_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CH_TILDE || (b >= CH_A && b <= CH_D)) b = ASCII_LBRACKET;
    return b;
  endfunction

  function automatic logic [7:0] random_terminator();
    int pick;
    pick = $urandom_range(4);
    return (pick == 4) ? CH_TILDE : CH_A + 8'(pick);
  endfunction

  // One burst of terminal activity. Most bursts are well-formed: typing,
  // editing, line submission, escape sequences finished by a terminator or by
  // the timeout, and armed repeats that fire. The rest is noise.
  task automatic queue_random_activity();
    int pick;
    int n;
    int d;
    pick = $urandom_range(99);
    if (pick < 22) begin
      repeat ($urandom_range(1, 8)) queue_byte(random_printable());
    end else if (pick < 30) begin
      repeat ($urandom_range(1, 3)) queue_byte($urandom_range(1) ? CH_BS : CH_DEL);
    end else if (pick < 38) begin
      queue_byte(CH_CR);
    end else if (pick < 55) begin
      queue_byte(CH_ESC);
      repeat ($urandom_range(0, 5)) begin
        queue_byte($urandom_range(1) ? random_inner_byte()
                                      : ASCII_DIGIT_0 + 8'($urandom_range(9)));
      end
      queue_byte(random_terminator());
    end else if (pick < 63) begin
      queue_byte(CH_ESC);
      repeat ($urandom_range(0, 2)) queue_byte(random_inner_byte());
      if (esc_timeout <= 16 && $urandom_range(3) != 0) begin
        queue_ticks(esc_timeout + 1 + $urandom_range(1));
      end else begin
        queue_ticks($urandom_range(0, 3));
        queue_byte(random_terminator());
      end
    end else if (pick < 73) begin
      d = $urandom_range(0, 4);
      queue_arm(16'(d));
      if ($urandom_range(9) < 3) begin
        // Cancel the repeat before it fires.
        queue_ticks($urandom_range(0, d));
        queue_byte($urandom_range(1) ? random_printable() : CH_ESC);
      end else begin
        queue_ticks(d + 1);
      end
    end else if (pick < 77) begin
      queue_byte($urandom_range(1) ? CH_HALT : CH_RESET);
    end else if (pick < 85) begin
      n = $urandom_range(2);
      if (n == 0) queue_byte(CH_LF);
      else if (n == 1) queue_byte(8'($urandom_range(0, 8'h1F)));
      else queue_byte(8'($urandom_range(8'h80, 8'hFF)));
    end else if (pick < 89) begin
      // A repeat armed in the middle of gathering takes over the timer.
      d = $urandom_range(0, 3);
      queue_byte(CH_ESC);
      queue_byte(ASCII_LBRACKET);
      queue_arm(16'(d));
      queue_ticks(d + 1);
    end else begin
      n = $urandom_range(3);
      if (n == 0) queue_byte(8'($urandom_range(255)));
      else if (n == 1) queue_ticks(1);
      else if (n == 2) queue_input(KIND_UNUSED, 8'($urandom), 16'($urandom));
      else queue_arm(16'($urandom));
    end
  endtask

  task automatic queue_random_phase(input int count);
    int goal;
    goal = inputs_queued_total + count;
    while (inputs_queued_total < goal) queue_random_activity();
  endtask

  // Sender pause: wait until all input is taken and every predicted result has
  // come back, then let the block settle before anything else changes.
  task automatic wait_until_drained();
    while (terminal_inputs_queued.size() != 0 || item_valid ||
           terminal_outputs_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_escape_timeout(input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    esc_timeout = v;
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed checks with the timeout at its reset value.
    // A repeat before any sequence replays the cleared code, which echoes as <00>.
    queue_arm(16'd0);
    queue_ticks(1);
    queue_input(KIND_UNUSED, 8'hFF, 16'hFFFF);
    queue_byte(CH_PRINT_LO);
    queue_byte(CH_PRINT_HI);
    queue_byte(CH_DEL);
    queue_byte(CH_BS);
    queue_byte(CH_BS);
    queue_byte(CH_LF);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(CH_HALT);
    queue_byte(CH_RESET);
    queue_byte(CH_ESC);
    queue_byte(ASCII_LBRACKET);
    queue_byte(CH_A);
    // Four bytes after ESC push it out; what is left is a plain 'D'.
    queue_byte(CH_ESC);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(CH_D);
    // A byte while a repeat is armed cancels it and is handled directly.
    queue_arm(16'd3);
    queue_byte(ASCII_X);
    queue_arm(16'd2);
    queue_byte(CH_ESC);
    queue_byte(CH_TILDE);
    queue_byte(CH_CR);
    wait_until_drained();

    // Timeout zero, with no idling on either side for the whole phase.
    write_escape_timeout(8'd0);
    quiet_phase = 1'b1;
    queue_byte(CH_ESC);
    queue_ticks(1);
    queue_byte(CH_ESC);
    queue_arm(16'd1);
    queue_ticks(2);
    // Overfill the line, then submit it.
    repeat (LINE_DEPTH + 3) queue_byte(random_printable());
    queue_byte(CH_CR);
    queue_random_phase(20);
    wait_until_drained();
    quiet_phase = 1'b0;

    // Longest timeout: the count runs down for a while and a terminator then
    // closes the sequence well before it would expire.
    write_escape_timeout(8'd255);
    queue_byte(CH_ESC);
    queue_byte(ASCII_LBRACKET);
    queue_ticks(20);
    queue_byte(random_terminator());
    queue_random_phase(10);
    wait_until_drained();

    repeat (3) begin
      write_escape_timeout(8'($urandom_range(1, 12)));
      queue_random_phase(15);
      wait_until_drained();
    end

    write_escape_timeout(TIMEOUT_RESET);
    queue_random_phase(10);
    wait_until_drained();

    $display("Covered %0d input transactions and %0d result transactions,", inputs_accepted,
             outputs_checked);
    $display("with escape timeouts of 5, 0, 255 and several random values.");
    if (mismatch_count == 0 && terminal_outputs_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
